FILE: rtl/fqmtf_pkg.sv
`timescale 1ns / 1ps

package fqmtf_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    typedef enum logic [1:0] {
        K_ENQ  = 2'd0,
        K_DEQ  = 2'd1,
        K_MOVE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_FRONT_RD,
        S_FRONT_LD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT_FRONT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        start;
    } entry_t;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic [31:0]        front_start;
        logic [4:0]         entry_count;
        logic               is_empty;
        status_t            status;
    } result_t;

endpackage

FILE: rtl/fqmtf_cmd_if.sv
`timescale 1ns / 1ps

interface fqmtf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [31:0]        start_time;

    modport source (output valid, output kind, output value, output start_time, input ready);
    modport sink (input valid, input kind, input value, input start_time, output ready);
endinterface

FILE: rtl/fqmtf_res_if.sv
`timescale 1ns / 1ps

interface fqmtf_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_value;
    logic [31:0]        front_start;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;

    modport source (
        output valid, output front_value, output front_start,
        output entry_count, output is_empty, output status, input ready
    );
    modport sink (
        input valid, input front_value, input front_start,
        input entry_count, input is_empty, input status, output ready
    );
endinterface

FILE: rtl/fqmtf_slot.sv
`timescale 1ns / 1ps

module fqmtf_slot
    import fqmtf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic [AW-1:0] head,
    input  logic [CW-1:0] pos,
    output logic [AW-1:0] slot
);

    logic [CW:0] sum;
    logic [CW:0] wrapped;

    // head and pos both stay below the depth, so one subtract is enough
    always_comb
    begin
        sum     = (CW+1)'(head) + (CW+1)'(pos);
        wrapped = (sum >= (CW+1)'(QUEUE_DEPTH)) ? sum - (CW+1)'(QUEUE_DEPTH) : sum;
        slot    = wrapped[AW-1:0];
    end

endmodule

FILE: rtl/fqmtf_mem.sv
`timescale 1ns / 1ps

module fqmtf_mem
    import fqmtf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  entry_t        wr_data,
    output entry_t        rd_data
);

    entry_t mem_reg [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fqmtf_seq.sv
`timescale 1ns / 1ps

module fqmtf_seq
    import fqmtf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic [1:0]         cmd_kind,
    input  logic signed [31:0] cmd_value,
    input  logic [31:0]        cmd_start,
    output logic               cmd_ready,
    output logic               done_valid,
    input  logic               done_ready,
    output result_t            done_result,
    output logic               mem_wr_en,
    output logic               mem_rd_en,
    output logic [AW-1:0]      mem_addr,
    output entry_t             mem_wr_data,
    input  entry_t             mem_rd_data
);

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic [31:0]        start_reg, start_next;
    entry_t             mv_reg, mv_next;
    entry_t             front_reg, front_next;
    status_t            status_reg, status_next;

    logic [CW-1:0] slot_pos;
    logic [CW-1:0] pos_inc;
    logic [AW-1:0] head_inc;
    logic          occ_empty;
    logic          occ_full;
    logic          hit;
    logic [31:0]   occ_ext;

    // the one address unit: every memory access goes through it
    fqmtf_slot #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_slot (
        .head (head_reg),
        .pos  (slot_pos),
        .slot (mem_addr)
    );

    assign occ_empty = (occ_reg == '0);
    assign occ_full  = (occ_reg == CW'(QUEUE_DEPTH));
    assign pos_inc   = pos_reg + CW'(1);
    assign head_inc  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign hit       = (mem_rd_data.value == val_reg);
    assign occ_ext   = 32'(occ_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_kind)
                        K_ENQ:   state_next = occ_full ? S_DONE : S_ENQ;
                        K_DEQ:   state_next = (occ_reg > CW'(1)) ? S_FRONT_RD : S_DONE;
                        K_MOVE:  state_next = occ_empty ? S_DONE : S_SCAN_RD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_ENQ:       state_next = S_DONE;
            S_FRONT_RD:  state_next = S_FRONT_LD;
            S_FRONT_LD:  state_next = S_DONE;
            S_SCAN_RD:   state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    state_next = (pos_reg == '0) ? S_DONE : S_SHIFT_RD;
                end
                else
                begin
                    state_next = (pos_inc == occ_reg) ? S_DONE : S_SCAN_RD;
                end
            end
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = (pos_reg == CW'(1)) ? S_PUT_FRONT : S_SHIFT_RD;
            S_PUT_FRONT: state_next = S_DONE;
            S_DONE:      state_next = done_ready ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        start_next  = start_reg;
        mv_next     = mv_reg;
        front_next  = front_reg;
        status_next = status_reg;
        slot_pos    = pos_reg;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_data = mem_rd_data;
        cmd_ready   = 1'b0;
        done_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    val_next    = cmd_value;
                    start_next  = cmd_start;
                    pos_next    = '0;
                    status_next = ST_OK;
                    case (cmd_kind)
                        K_ENQ:
                        begin
                            if (occ_full)
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        K_DEQ:
                        begin
                            if (occ_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                head_next = head_inc;
                                occ_next  = occ_reg - CW'(1);
                            end
                        end
                        K_MOVE:
                        begin
                            if (occ_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end
            S_ENQ:
            begin
                slot_pos    = occ_reg;
                mem_wr_en   = 1'b1;
                mem_wr_data = '{value: val_reg, start: start_reg};
                occ_next    = occ_reg + CW'(1);
                if (occ_empty)
                begin
                    front_next = '{value: val_reg, start: start_reg};
                end
            end
            S_FRONT_RD:
            begin
                slot_pos  = '0;
                mem_rd_en = 1'b1;
            end
            S_FRONT_LD:
            begin
                front_next = mem_rd_data;
            end
            S_SCAN_RD:
            begin
                mem_rd_en = 1'b1;
            end
            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    mv_next = mem_rd_data;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (pos_inc == occ_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                // fetch the entry one place nearer the front
                slot_pos  = pos_reg - CW'(1);
                mem_rd_en = 1'b1;
            end
            S_SHIFT_WR:
            begin
                mem_wr_en = 1'b1;
                pos_next  = pos_reg - CW'(1);
            end
            S_PUT_FRONT:
            begin
                slot_pos    = '0;
                mem_wr_en   = 1'b1;
                mem_wr_data = mv_reg;
                front_next  = mv_reg;
            end
            S_DONE:
            begin
                done_valid = 1'b1;
            end
            default:
            begin
                done_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        done_result.front_value = occ_empty ? 32'sd0 : front_reg.value;
        done_result.front_start = occ_empty ? 32'd0 : front_reg.start;
        done_result.entry_count = occ_ext[4:0];
        done_result.is_empty    = occ_empty;
        done_result.status      = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        start_reg  <= start_next;
        mv_reg     <= mv_next;
        front_reg  <= front_next;
        status_reg <= status_next;
    end

endmodule

FILE: rtl/fifo_queue_with_move_to_front_top.sv
`timescale 1ns / 1ps

// Bounded queue of QUEUE_DEPTH entries (signed value, start time) with enqueue, dequeue and
// move-to-front commands; every command returns one item with the front entry, the count,
// an empty flag and a status. The entries sit in a single-port memory (one read or one write
// per cycle, registered read) and a small sequencer drives one shared slot-address unit, so
// commands are handled one at a time: enqueue writes the new entry, dequeue advances the
// head and reads the new front (unless it took the last entry), a refused command goes
// straight to its result, and a move reads entries from the front until one matches, shifts
// the entries ahead of the match back one place and writes it to the front. The result sits
// in an output register, so the next command is taken while it waits to be read.
module fifo_queue_with_move_to_front_top
    import fqmtf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int AW = $clog2(QUEUE_DEPTH)
)
(
    input  logic        clk,
    input  logic        rst_n,
    fqmtf_cmd_if.sink   cmd,
    fqmtf_res_if.source res
);

    logic          done_valid;
    logic          done_ready;
    result_t       done_result;
    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wr_data;
    entry_t        mem_rd_data;
    result_t       res_reg;
    logic          res_valid_reg;

    fqmtf_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_kind    (cmd.kind),
        .cmd_value   (cmd.value),
        .cmd_start   (cmd.start_time),
        .cmd_ready   (cmd.ready),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .done_result (done_result),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    fqmtf_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign done_ready = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done_valid && done_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            res_reg <= done_result;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.front_value = res_reg.front_value;
    assign res.front_start = res_reg.front_start;
    assign res.entry_count = res_reg.entry_count;
    assign res.is_empty    = res_reg.is_empty;
    assign res.status      = res_reg.status;

    // an empty queue reports a zero front and can never be full
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.is_empty) |->
            (res_reg.front_value == 32'sd0 && res_reg.front_start == 32'd0 &&
             res_reg.status != ST_FULL))
        else $error("empty result carries front data or full status");

    // one command at a time: the sequencer leaves idle once a command is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while the previous one still runs");

    // a finished command always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && done_ready) |=> res_valid_reg)
        else $error("finished result lost before output register");

endmodule
